// ----- hdl/ocema_pkg.sv -----
package ocema_pkg;

  localparam int NCH          = 4;
  localparam int CHANNELS     = 4;
  localparam int CALIB_SCANS  = 5;
  localparam int FILTER_SHIFT = 8;

  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 10;
  localparam int PROD_W     = SAMPLE_W + GAIN_W;
  localparam int OFFSET_W   = 25;
  localparam int AMP_OUT_W  = 23;
  localparam int VOLT_X_W   = 16;

  localparam int RAW_STATE_W  = SAMPLE_W + FILTER_SHIFT;
  localparam int AMP_STATE_W  = AMP_OUT_W + FILTER_SHIFT;
  localparam int VOLT_STATE_W = VOLT_X_W + FILTER_SHIFT;
  localparam int AMP_D_W      = OFFSET_W + 1;
  localparam int AMP_DIFF_W   = AMP_D_W + FILTER_SHIFT + 1;

  localparam int SCAN_W = $clog2(CALIB_SCANS + 1);

  // Truncating division of the offset sum by the scan count as a reciprocal multiply.
  localparam int DIV_SHIFT  = OFFSET_W + $clog2(CALIB_SCANS);
  localparam int DIV_MULT_W = DIV_SHIFT + 1;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT =
    DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(CALIB_SCANS) - 64'd1) / 64'(CALIB_SCANS));

  // The voltage input is (sample + 400) * 4.5, held in Q1.
  localparam int VOLT_OFFSET = 400;
  localparam int VOLT_SCALE  = 9;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH0 = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH1 = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_CH3 = 2'd3;

  typedef logic [NCH-1:0][GAIN_W-1:0]    gain_bank_t;
  typedef logic [NCH-1:0][SAMPLE_W-1:0]  sample_bank_t;
  typedef logic [NCH-1:0][PROD_W-1:0]    prod_bank_t;
  typedef logic [NCH-1:0][AMP_OUT_W-1:0] amp_bank_t;

  localparam gain_bank_t GAIN_RESET = {10'd312, 10'd312, 10'd387, 10'd312};

  typedef struct packed {
    logic commit;
    logic calib;
    logic calib_last;
  } lane_ctl_t;

endpackage

// ----- hdl/ocema_cfg.sv -----
module ocema_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ocema_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ocema_pkg::GAIN_W-1:0]          cfg_data,
  output ocema_pkg::gain_bank_t                 gains
);

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= ocema_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ocema_pkg::REG_GAIN_CH0: gains[0] <= cfg_data;
        ocema_pkg::REG_GAIN_CH1: gains[1] <= cfg_data;
        ocema_pkg::REG_GAIN_CH2: gains[2] <= cfg_data;
        ocema_pkg::REG_GAIN_CH3: gains[3] <= cfg_data;
        default: gains <= gains;
      endcase
    end
  end

endmodule

// ----- hdl/ocema_front.sv -----
module ocema_front (
  input  logic                                clk,
  input  logic                                load,
  input  ocema_pkg::gain_bank_t               gains,
  input  logic [ocema_pkg::SAMPLE_W-1:0]      sample_ch0,
  input  logic [ocema_pkg::SAMPLE_W-1:0]      sample_ch1,
  input  logic [ocema_pkg::SAMPLE_W-1:0]      sample_ch2,
  input  logic [ocema_pkg::SAMPLE_W-1:0]      sample_ch3,
  input  logic [ocema_pkg::SAMPLE_W-1:0]      sample_volt,
  output ocema_pkg::sample_bank_t             stage_sample,
  output ocema_pkg::prod_bank_t               stage_prod,
  output logic [ocema_pkg::VOLT_X_W-1:0]      stage_volt
);

  ocema_pkg::sample_bank_t           sample_in;
  ocema_pkg::prod_bank_t             prod_next;
  logic [ocema_pkg::VOLT_X_W-1:0]    volt_next;

  assign sample_in = {sample_ch3, sample_ch2, sample_ch1, sample_ch0};

  always_comb begin
    for (int i = 0; i < ocema_pkg::NCH; i++) begin
      prod_next[i] = ocema_pkg::PROD_W'(gains[i]) * ocema_pkg::PROD_W'(sample_in[i]);
    end
  end

  assign volt_next = (ocema_pkg::VOLT_X_W'(sample_volt)
                      + ocema_pkg::VOLT_X_W'(ocema_pkg::VOLT_OFFSET))
                     * ocema_pkg::VOLT_X_W'(ocema_pkg::VOLT_SCALE);

  always_ff @(posedge clk) begin
    if (load) begin
      stage_sample <= sample_in;
      stage_prod   <= prod_next;
      stage_volt   <= volt_next;
    end
  end

endmodule

// ----- hdl/ocema_lane.sv -----
module ocema_lane (
  input  logic                                       clk,
  input  logic                                       rst,
  input  ocema_pkg::lane_ctl_t                       ctl,
  input  logic [ocema_pkg::SAMPLE_W-1:0]             sample,
  input  logic [ocema_pkg::PROD_W-1:0]               prod,
  output logic [ocema_pkg::SAMPLE_W-1:0]             raw_avg,
  output logic signed [ocema_pkg::AMP_OUT_W-1:0]     amp_avg
);

  localparam int F      = ocema_pkg::FILTER_SHIFT;
  localparam int RAW_W  = ocema_pkg::RAW_STATE_W;
  localparam int AMP_W  = ocema_pkg::AMP_STATE_W;
  localparam int OFS_W  = ocema_pkg::OFFSET_W;
  localparam int D_W    = ocema_pkg::AMP_D_W;
  localparam int DIFF_W = ocema_pkg::AMP_DIFF_W;
  localparam int QUOT_W = OFS_W + ocema_pkg::DIV_MULT_W;

  logic [RAW_W-1:0]         raw_state;
  logic [RAW_W-1:0]         raw_next;
  logic [AMP_W-1:0]         amp_state;
  logic [AMP_W-1:0]         amp_next;
  logic [OFS_W-1:0]         offset_store;
  logic [OFS_W-1:0]         offset_next;

  logic [OFS_W-1:0]         offset_sum;
  logic [QUOT_W-1:0]        quot_full;
  logic signed [RAW_W:0]    raw_diff;
  logic signed [RAW_W:0]    raw_step;
  logic signed [D_W-1:0]    amp_d;
  logic signed [DIFF_W-1:0] amp_diff;
  logic signed [DIFF_W-1:0] amp_step;

  assign offset_sum = offset_store + OFS_W'(prod);
  assign quot_full  = QUOT_W'(offset_sum) * QUOT_W'(ocema_pkg::DIV_MULT);

  assign raw_diff = $signed({1'b0, sample, {F{1'b0}}}) - $signed({1'b0, raw_state});
  assign raw_step = raw_diff >>> F;

  assign amp_d    = $signed({1'b0, OFS_W'(prod)}) - $signed({1'b0, offset_store});
  assign amp_diff = $signed({{(DIFF_W - F - D_W){amp_d[D_W-1]}}, amp_d, {F{1'b0}}})
                    - $signed({{(DIFF_W - AMP_W){amp_state[AMP_W-1]}}, amp_state});
  assign amp_step = amp_diff >>> F;

  always_comb begin
    raw_next    = raw_state;
    amp_next    = amp_state;
    offset_next = offset_store;
    if (ctl.calib) begin
      offset_next = ctl.calib_last ? quot_full[ocema_pkg::DIV_SHIFT +: OFS_W] : offset_sum;
    end else begin
      raw_next = raw_state + raw_step[RAW_W-1:0];
      amp_next = amp_state + amp_step[AMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_state    <= '0;
      amp_state    <= '0;
      offset_store <= '0;
    end else if (ctl.commit) begin
      raw_state    <= raw_next;
      amp_state    <= amp_next;
      offset_store <= offset_next;
    end
  end

  assign raw_avg = raw_next[F +: ocema_pkg::SAMPLE_W];
  assign amp_avg = amp_next[F +: ocema_pkg::AMP_OUT_W];

endmodule

// ----- hdl/offset_calibrated_ema_adc_filter_unit.sv -----
// An accepted scan moves from the input register to the result register that out_valid marks.
// One scan per cycle unless stalled; the input register holds one more scan while a result waits.
// The gain multiplies sit before the input register, the filter updates before the result register.
// Reset (rst, synchronous) restores the default gains and clears all filters, offsets and the
// calibration count, so the next five scans gather offsets again.
module offset_calibrated_ema_adc_filter_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ocema_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ocema_pkg::GAIN_W-1:0]             cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [ocema_pkg::SAMPLE_W-1:0]           sample_ch0,
  input  logic [ocema_pkg::SAMPLE_W-1:0]           sample_ch1,
  input  logic [ocema_pkg::SAMPLE_W-1:0]           sample_ch2,
  input  logic [ocema_pkg::SAMPLE_W-1:0]           sample_ch3,
  input  logic [ocema_pkg::SAMPLE_W-1:0]           sample_volt,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [ocema_pkg::SAMPLE_W-1:0]           raw_avg_ch0,
  output logic [ocema_pkg::SAMPLE_W-1:0]           raw_avg_ch1,
  output logic [ocema_pkg::SAMPLE_W-1:0]           raw_avg_ch2,
  output logic [ocema_pkg::SAMPLE_W-1:0]           raw_avg_ch3,
  output logic signed [ocema_pkg::AMP_OUT_W-1:0]   amp_avg_ch0,
  output logic signed [ocema_pkg::AMP_OUT_W-1:0]   amp_avg_ch1,
  output logic signed [ocema_pkg::AMP_OUT_W-1:0]   amp_avg_ch2,
  output logic signed [ocema_pkg::AMP_OUT_W-1:0]   amp_avg_ch3,
  output logic [ocema_pkg::VOLT_X_W-1:0]           volt_avg,
  output logic                                     calibrating
);

  localparam int F      = ocema_pkg::FILTER_SHIFT;
  localparam int VOLT_W = ocema_pkg::VOLT_STATE_W;
  localparam int SCAN_W = ocema_pkg::SCAN_W;

  ocema_pkg::gain_bank_t            gains;
  ocema_pkg::sample_bank_t          stage_sample;
  ocema_pkg::prod_bank_t            stage_prod;
  logic [ocema_pkg::VOLT_X_W-1:0]   stage_volt;
  logic                             stage_valid;

  ocema_pkg::sample_bank_t          lane_raw;
  ocema_pkg::amp_bank_t             lane_amp;
  ocema_pkg::lane_ctl_t             lane_ctl;

  logic                             in_accept;
  logic                             out_free;
  logic                             commit;
  logic                             calib;
  logic [SCAN_W-1:0]                scan_count;

  logic [VOLT_W-1:0]                volt_state;
  logic [VOLT_W-1:0]                volt_next;
  logic signed [VOLT_W:0]           volt_diff;
  logic signed [VOLT_W:0]           volt_step;

  assign cfg_ready = 1'b1;

  assign out_free  = !out_valid || !out_stall;
  assign commit    = stage_valid && out_free;
  assign in_stall  = stage_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  assign calib = scan_count < SCAN_W'(ocema_pkg::CALIB_SCANS);

  assign lane_ctl.commit     = commit;
  assign lane_ctl.calib      = calib;
  assign lane_ctl.calib_last = scan_count == SCAN_W'(ocema_pkg::CALIB_SCANS - 1);

  ocema_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gains     (gains)
  );

  ocema_front u_front (
    .clk          (clk),
    .load         (in_accept),
    .gains        (gains),
    .sample_ch0   (sample_ch0),
    .sample_ch1   (sample_ch1),
    .sample_ch2   (sample_ch2),
    .sample_ch3   (sample_ch3),
    .sample_volt  (sample_volt),
    .stage_sample (stage_sample),
    .stage_prod   (stage_prod),
    .stage_volt   (stage_volt)
  );

  for (genvar i = 0; i < ocema_pkg::NCH; i++) begin : g_lane
    if (i < ocema_pkg::CHANNELS) begin : g_on
      ocema_lane u_lane (
        .clk     (clk),
        .rst     (rst),
        .ctl     (lane_ctl),
        .sample  (stage_sample[i]),
        .prod    (stage_prod[i]),
        .raw_avg (lane_raw[i]),
        .amp_avg (lane_amp[i])
      );
    end else begin : g_off
      assign lane_raw[i] = '0;
      assign lane_amp[i] = '0;
    end
  end

  assign volt_diff = $signed({1'b0, stage_volt, {F{1'b0}}}) - $signed({1'b0, volt_state});
  assign volt_step = volt_diff >>> F;
  assign volt_next = volt_state + volt_step[VOLT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
      scan_count  <= '0;
      volt_state  <= '0;
    end else begin
      if (in_accept) begin
        stage_valid <= 1'b1;
      end else if (commit) begin
        stage_valid <= 1'b0;
      end
      if (commit) begin
        out_valid  <= 1'b1;
        volt_state <= volt_next;
        if (calib) begin
          scan_count <= scan_count + SCAN_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      raw_avg_ch0 <= lane_raw[0];
      raw_avg_ch1 <= lane_raw[1];
      raw_avg_ch2 <= lane_raw[2];
      raw_avg_ch3 <= lane_raw[3];
      amp_avg_ch0 <= lane_amp[0];
      amp_avg_ch1 <= lane_amp[1];
      amp_avg_ch2 <= lane_amp[2];
      amp_avg_ch3 <= lane_amp[3];
      volt_avg    <= volt_next[F +: ocema_pkg::VOLT_X_W];
      calibrating <= calib;
    end
  end

`ifndef SYNTHESIS
  a_scan_count_bound: assert property (@(posedge clk) disable iff (rst)
    scan_count <= SCAN_W'(ocema_pkg::CALIB_SCANS))
    else $error("scan counter ran past the calibration length");

  a_calib_stays_done: assert property (@(posedge clk) disable iff (rst)
    !calib |=> !calib)
    else $error("calibration restarted without reset");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("filter update gave no result beat");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (stage_valid && out_valid))
    else $error("input stalled while buffering space was free");
`endif

endmodule

// ----- tb/offset_calibrated_ema_adc_filter_unit_tb.sv -----
`timescale 1ns / 1ps

module offset_calibrated_ema_adc_filter_unit_tb;

  localparam int RAND_PER_PHASE = 346;
  localparam int PRESSURE_AT = 100;
  localparam int PRESSURE_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [0:0] {DIR_SCAN, DIR_GAINS} dir_op_t;

  typedef struct packed {
    dir_op_t op;
    int a0;
    int a1;
    int a2;
    int a3;
    int a4;
    bit typed;
    int e_volt;
    bit e_cal;
  } dir_row_t;

  typedef struct packed {
    ocema_pkg::sample_bank_t ch;
    logic [ocema_pkg::SAMPLE_W-1:0] volt;
  } scan_t;

  typedef struct packed {
    ocema_pkg::sample_bank_t raw;
    ocema_pkg::amp_bank_t amp;
    logic [ocema_pkg::VOLT_X_W-1:0] volt;
    logic cal;
  } filt_result_t;

  localparam logic [ocema_pkg::CFG_INDEX_W-1:0] GAIN_REGS [ocema_pkg::NCH] =
    '{ocema_pkg::REG_GAIN_CH0, ocema_pkg::REG_GAIN_CH1,
      ocema_pkg::REG_GAIN_CH2, ocema_pkg::REG_GAIN_CH3};

  // For gain rows a0..a3 are the four gains. Typed rows expect zero raw and amp averages.
  localparam int DIR_N = 21;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{DIR_SCAN,  0,    0,    0,    0,    0,    1'b1, 14, 1'b1},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 0,    1'b1, 28, 1'b1},
    '{DIR_GAINS, 0,    1023, 1,    512,  0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 4095, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  2048, 1,    4094, 2730, 1365, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  1365, 2730, 2048, 4094, 2048, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  0,    0,    0,    0,    4095, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 0,    4095, 0,    4095, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  2730, 1365, 2730, 1365, 2730, 1'b0, 0,  1'b0},
    '{DIR_GAINS, 1023, 1023, 1023, 1023, 0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 4095, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  0,    0,    0,    0,    0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 0,    1'b0, 0,  1'b0},
    '{DIR_GAINS, 0,    0,    0,    0,    0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  0,    0,    0,    0,    0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  4095, 4095, 4095, 4095, 4095, 1'b0, 0,  1'b0},
    '{DIR_SCAN,  1234, 2345, 3456, 567,  789,  1'b0, 0,  1'b0},
    '{DIR_GAINS, 312,  387,  312,  312,  0,    1'b0, 0,  1'b0},
    '{DIR_SCAN,  100,  200,  300,  400,  500,  1'b0, 0,  1'b0},
    '{DIR_SCAN,  3000, 3100, 3200, 3300, 3400, 1'b0, 0,  1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ocema_pkg::CFG_INDEX_W-1:0] cfg_index = ocema_pkg::REG_GAIN_CH0;
  logic [ocema_pkg::GAIN_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ocema_pkg::SAMPLE_W-1:0] sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_volt;
  logic [ocema_pkg::SAMPLE_W-1:0] raw_avg_ch0, raw_avg_ch1, raw_avg_ch2, raw_avg_ch3;
  logic signed [ocema_pkg::AMP_OUT_W-1:0] amp_avg_ch0, amp_avg_ch1, amp_avg_ch2, amp_avg_ch3;
  logic [ocema_pkg::VOLT_X_W-1:0] volt_avg;
  logic calibrating;

  scan_t cur_scan = '0;
  bit next_typed = 1'b0;
  filt_result_t typed_exp = '0;
  filt_result_t pending_results [$];

  ocema_pkg::gain_bank_t gain_q = ocema_pkg::GAIN_RESET;
  logic [ocema_pkg::RAW_STATE_W-1:0] raw_acc [ocema_pkg::NCH] = '{default: '0};
  logic signed [ocema_pkg::AMP_STATE_W-1:0] amp_acc [ocema_pkg::NCH] = '{default: '0};
  logic [ocema_pkg::VOLT_STATE_W-1:0] volt_acc = '0;
  logic [ocema_pkg::OFFSET_W-1:0] offset_sum [ocema_pkg::NCH] = '{default: '0};
  logic [ocema_pkg::SCAN_W-1:0] scan_cnt = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int scans_in = 0;
  int results_seen = 0;
  int gain_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  assign sample_ch0 = cur_scan.ch[0];
  assign sample_ch1 = cur_scan.ch[1];
  assign sample_ch2 = cur_scan.ch[2];
  assign sample_ch3 = cur_scan.ch[3];
  assign sample_volt = cur_scan.volt;

  offset_calibrated_ema_adc_filter_unit i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_ch0(sample_ch0),
    .sample_ch1(sample_ch1),
    .sample_ch2(sample_ch2),
    .sample_ch3(sample_ch3),
    .sample_volt(sample_volt),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .raw_avg_ch0(raw_avg_ch0),
    .raw_avg_ch1(raw_avg_ch1),
    .raw_avg_ch2(raw_avg_ch2),
    .raw_avg_ch3(raw_avg_ch3),
    .amp_avg_ch0(amp_avg_ch0),
    .amp_avg_ch1(amp_avg_ch1),
    .amp_avg_ch2(amp_avg_ch2),
    .amp_avg_ch3(amp_avg_ch3),
    .volt_avg(volt_avg),
    .calibrating(calibrating)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint ema_step(longint acc, longint x);
    return acc + (((x <<< ocema_pkg::FILTER_SHIFT) - acc) >>> ocema_pkg::FILTER_SHIFT);
  endfunction

  function automatic filt_result_t filter_scan(scan_t sc);
    filt_result_t r;
    longint s;
    longint d;
    longint a;
    longint x;
    logic calib;
    r = '0;
    calib = (scan_cnt < ocema_pkg::CALIB_SCANS);
    if (calib) begin
      for (int c = 0; c < ocema_pkg::CHANNELS; c++) begin
        offset_sum[c] = ocema_pkg::OFFSET_W'(longint'(offset_sum[c]) +
                                             longint'(gain_q[c]) * longint'(sc.ch[c]));
      end
      scan_cnt = scan_cnt + 1'b1;
      if (scan_cnt == ocema_pkg::CALIB_SCANS) begin
        for (int c = 0; c < ocema_pkg::CHANNELS; c++) begin
          offset_sum[c] = ocema_pkg::OFFSET_W'(offset_sum[c] / ocema_pkg::CALIB_SCANS);
        end
      end
    end else begin
      for (int c = 0; c < ocema_pkg::CHANNELS; c++) begin
        s = longint'(sc.ch[c]);
        d = longint'(gain_q[c]) * s - longint'(offset_sum[c]);
        raw_acc[c] = ocema_pkg::RAW_STATE_W'(ema_step(longint'(raw_acc[c]), s));
        a = amp_acc[c];
        amp_acc[c] = ocema_pkg::AMP_STATE_W'(ema_step(a, d));
      end
    end
    x = (longint'(sc.volt) + ocema_pkg::VOLT_OFFSET) * ocema_pkg::VOLT_SCALE;
    volt_acc = ocema_pkg::VOLT_STATE_W'(ema_step(longint'(volt_acc), x));
    for (int c = 0; c < ocema_pkg::CHANNELS; c++) begin
      r.raw[c] = ocema_pkg::SAMPLE_W'(raw_acc[c] >> ocema_pkg::FILTER_SHIFT);
      a = amp_acc[c];
      r.amp[c] = ocema_pkg::AMP_OUT_W'(a >>> ocema_pkg::FILTER_SHIFT);
    end
    r.volt = ocema_pkg::VOLT_X_W'(volt_acc >> ocema_pkg::FILTER_SHIFT);
    r.cal = calib;
    return r;
  endfunction

  function automatic logic [ocema_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return ocema_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    filt_result_t got;
    filt_result_t want;
    filt_result_t pred;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        gain_q[cfg_index] = cfg_data;
        gain_writes++;
      end
      if (out_valid && !out_stall) begin
        got.raw = {raw_avg_ch3, raw_avg_ch2, raw_avg_ch1, raw_avg_ch0};
        got.amp = {amp_avg_ch3, amp_avg_ch2, amp_avg_ch1, amp_avg_ch0};
        got.volt = volt_avg;
        got.cal = calibrating;
        if (pending_results.size() == 0) begin
          $error("result beat with no scan waiting for it");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          for (int c = 0; c < ocema_pkg::NCH; c++) begin
            check_field($sformatf("raw_avg_ch%0d", c), want.raw[c], got.raw[c]);
            check_field($sformatf("amp_avg_ch%0d", c), $signed(want.amp[c]),
                        $signed(got.amp[c]));
          end
          check_field("volt_avg", want.volt, got.volt);
          check_field("calibrating", want.cal, got.cal);
        end
      end
      if (in_valid && !in_stall) begin
        pred = filter_scan(cur_scan);
        if (next_typed) begin
          pred = typed_exp;
        end
        pending_results.push_back(pred);
        scans_in++;
      end
    end
  end

  always @(negedge clk) begin
    if (!pressure_done && scans_in >= PRESSURE_AT) begin
      hold_left = PRESSURE_CYCLES;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_scan(input scan_t sc);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    cur_scan = sc;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  task automatic write_gains(input ocema_pkg::gain_bank_t g);
    cfg_valid = 1'b1;
    for (int r = 0; r < ocema_pkg::NCH; r++) begin
      cfg_index = GAIN_REGS[r];
      cfg_data = g[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_phase(input int idle, input int stall);
    @(posedge clk);
    idle_pct = idle;
    stall_pct = stall;
    @(negedge clk);
  endtask

  initial begin
    dir_row_t row;
    scan_t sc;
    ocema_pkg::gain_bank_t g;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_ROWS[i];
      if (row.op == DIR_GAINS) begin
        wait_idle();
        g[0] = ocema_pkg::GAIN_W'(row.a0);
        g[1] = ocema_pkg::GAIN_W'(row.a1);
        g[2] = ocema_pkg::GAIN_W'(row.a2);
        g[3] = ocema_pkg::GAIN_W'(row.a3);
        write_gains(g);
      end else begin
        sc.ch[0] = ocema_pkg::SAMPLE_W'(row.a0);
        sc.ch[1] = ocema_pkg::SAMPLE_W'(row.a1);
        sc.ch[2] = ocema_pkg::SAMPLE_W'(row.a2);
        sc.ch[3] = ocema_pkg::SAMPLE_W'(row.a3);
        sc.volt = ocema_pkg::SAMPLE_W'(row.a4);
        next_typed = row.typed;
        typed_exp = '0;
        typed_exp.volt = ocema_pkg::VOLT_X_W'(row.e_volt);
        typed_exp.cal = row.e_cal;
        send_scan(sc);
      end
    end
    next_typed = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      for (int r = 0; r < ocema_pkg::NCH; r++) begin
        case (ph)
          1: g[r] = '1;
          2: g[r] = '0;
          default: g[r] = ocema_pkg::GAIN_W'($urandom_range(0, 1023));
        endcase
      end
      write_gains(g);
      case (ph)
        0: set_phase(0, 0);
        1: set_phase(61, 0);
        2: set_phase(0, 61);
        default: set_phase(38, 38);
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        for (int c = 0; c < ocema_pkg::NCH; c++) begin
          sc.ch[c] = rand_sample();
        end
        sc.volt = rand_sample();
        send_scan(sc);
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Filtered %0d scans (calibration and four handshake mixes, one long output hold),",
             scans_in);
    $display("with %0d gain writes and %0d results compared field by field.",
             gain_writes, results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
